### hw/rtl/ol3sp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ol3sp_pkg: shared types and constants of the three-phase sine PWM unit
// Holds the sequencer states, register indexes, arithmetic constants and
// the build-time sine table generator.
// ----------------------------------------------------------------------------
package ol3sp_pkg;

    // Sine table size; must be a power of two (16 .. 4096)
    localparam int SINE_ENTRIES = 256;
    localparam int IDX_W        = $clog2(SINE_ENTRIES);
    localparam int FRAC_W       = 32 - IDX_W;
    // Interpolation product: signed level difference times the fraction
    localparam int MIX_W        = 18 + FRAC_W;

    localparam logic [31:0] ONE_THIRD_TURN = 32'h5555_5555;
    localparam logic [12:0] SPEED_GAIN     = 13'd4581;
    localparam int          P_W            = 44;
    localparam logic [6:0]  PCT_MAX        = 7'd100;
    // ceil(2^30 / 100): exact quotient for dividends below 2^23
    localparam logic [23:0] DIV100_MUL     = 24'd10737419;
    localparam int          DIV100_SHIFT   = 30;

    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [63:0] SERIES_DEN [6] = '{64'd6, 64'd20, 64'd42,
                                               64'd72, 64'd110, 64'd156};

    typedef logic [SINE_ENTRIES-1:0][15:0] t_sine_table;

    typedef enum logic [1:0] {
        CFG_PWM_PERIOD     = 2'd0,
        CFG_TORQUE_PERCENT = 2'd1,
        CFG_POLE_PAIRS     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_C
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ANGLE,
        S_ELEC,
        S_ADDR,
        S_RD1,
        S_RD2,
        S_LEVEL,
        S_SCALE,
        S_PCT,
        S_DIV,
        S_DONE
    } t_state;

    // sin(phi), phi in Q30 on [0, pi/2], rounded to Q1.15
    function automatic logic [15:0] quarter_sine(input logic [63:0] phi);
        logic [63:0]        phi2;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        phi2 = (phi * phi) >> 30;
        term = phi;
        sum  = 64'sd0;
        for (int k = 0; k < 6; k++) begin
            if ((k % 2) == 0) begin
                sum = sum + $signed(term);
            end else begin
                sum = sum - $signed(term);
            end
            term = ((term * phi2) >> 30) / SERIES_DEN[k];
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    // Fold each entry into the first quadrant and evaluate the series
    function automatic t_sine_table build_sine_table();
        t_sine_table tbl;
        logic [63:0] t;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] phi;
        logic [15:0] v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            t    = 64'(4 * i);
            quad = t / SINE_ENTRIES;
            rem  = t % SINE_ENTRIES;
            if (quad[0]) begin
                rem = 64'(SINE_ENTRIES) - rem;
            end
            phi = HALF_PI_Q30 * rem / SINE_ENTRIES;
            v   = quarter_sine(phi);
            if (quad >= 64'd2) begin
                v = 16'(-v);
            end
            tbl[i] = v;
        end
        return tbl;
    endfunction

    localparam t_sine_table SINE_TABLE = build_sine_table();

endpackage

### hw/rtl/open_loop_three_phase_sine_pwm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_loop_three_phase_sine_pwm_unit: open-loop sine commutation
// Integrates speed into a mechanical angle and produces three compare values.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one request per control update, carrying signed speed (rpm)
//   and elapsed time (us). It is taken when s_axis_tvalid and s_axis_tready
//   are both high; s_axis_tready is high only while the sequencer is idle.
//   Output stream: one request per update with the compare values of phases
//   A, B and C; B lags and C leads A by one third of a turn.
//   Each update walks the shared datapath through four angle steps, then
//   takes each of the three phases in turn through seven steps (two sine
//   ROM reads, interpolation, period and percent scaling, divide by
//   hundred). A new request is taken only once the sequencer is idle.
//   A finished result waits in the output register; while the receiver
//   stalls the next update is accepted and computed, and the sequencer holds
//   in its final step until the output register frees up.
//   Configuration writes (period, percent, pole pairs) are taken at any edge
//   with i_cfg_we high and belong between updates.
//   Reset (synchronous, active low) clears the angle, period and percent,
//   sets seven pole pairs and empties the output register. The sine ROM is
//   constant and needs no clearing.
// ----------------------------------------------------------------------------
module open_loop_three_phase_sine_pwm_unit
    import ol3sp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] speed, [31:16] elapsed_us
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [15:0] duty_a, [31:16] duty_b,
                                        // [47:32] duty_c
);

    // Configuration
    logic [15:0] r_period;
    logic [6:0]  r_pct;
    logic [5:0]  r_ppc;

    // Sequencer
    t_state      r_state;
    t_state      n_state;
    t_phase      r_phase;

    // Datapath
    logic [15:0]             r_speed;
    logic [15:0]             r_dt;
    logic                    r_neg;
    logic [31:0]             r_prod;
    logic [P_W-1:0]          r_p;
    logic [31:0]             r_angle;
    logic [31:0]             r_elec;
    logic [IDX_W-1:0]        r_idx;
    logic [FRAC_W-1:0]       r_frac;
    logic [15:0]             r_u0;
    logic signed [MIX_W-1:0] r_mix;
    logic [15:0]             r_v;
    logic [31:0]             r_scl;
    logic [22:0]             r_x;
    logic [15:0]             r_duty_a;
    logic [15:0]             r_duty_b;
    logic [15:0]             r_duty_c;

    // Sine ROM with registered read
    logic [15:0]      r_rom_q;
    logic [IDX_W-1:0] w_rom_addr;

    // Output register
    logic        r_out_vld;
    logic [47:0] r_out_data;

    logic              w_out_free;
    logic              w_load_out;
    logic [15:0]       w_mag;
    logic [P_W-1:0]    w_p_rnd;
    logic [31:0]       w_phase_ang;
    logic [15:0]       w_u1;
    logic signed [16:0] w_diff;
    logic signed [17:0] w_lvl;
    logic [6:0]        w_pct;
    logic [38:0]       w_x_full;
    logic [46:0]       w_q_full;
    logic [15:0]       w_q;

    assign w_out_free = !r_out_vld || m_axis_tready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_pct    <= '0;
            r_ppc    <= 6'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PWM_PERIOD:     r_period <= i_cfg_wdata;
                CFG_TORQUE_PERCENT: r_pct    <= i_cfg_wdata[6:0];
                CFG_POLE_PAIRS:     r_ppc    <= i_cfg_wdata[5:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Combinational datapath terms
    // ------------------------------------------------------------------
    // Magnitude of the speed; the most negative code maps to 32768
    assign w_mag   = r_speed[15] ? 16'(~r_speed + 16'd1) : r_speed;
    // Negative steps round the magnitude up so the shift floors the signed value
    assign w_p_rnd = r_p + P_W'(63);

    always_comb begin
        case (r_phase)
            PH_A:    w_phase_ang = r_elec;
            PH_B:    w_phase_ang = r_elec - ONE_THIRD_TURN;
            PH_C:    w_phase_ang = r_elec + ONE_THIRD_TURN;
            default: w_phase_ang = r_elec;
        endcase
    end

    // Offset the Q1.15 sample to unsigned by flipping the sign bit
    assign w_u1   = r_rom_q ^ 16'h8000;
    assign w_diff = $signed({1'b0, w_u1}) - $signed({1'b0, r_u0});
    assign w_lvl  = $signed({2'b00, r_u0}) + 18'(r_mix >>> FRAC_W);

    // Percent values above hundred act as hundred
    assign w_pct    = (r_pct > PCT_MAX) ? PCT_MAX : r_pct;
    assign w_x_full = 39'(r_scl) * 39'(w_pct);
    assign w_q_full = 47'(r_x) * 47'(DIV100_MUL);
    assign w_q      = w_q_full[DIV100_SHIFT +: 16];

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_ANGLE;
            S_ANGLE: n_state = S_ELEC;
            S_ELEC:  n_state = S_ADDR;
            S_ADDR:  n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_LEVEL;
            S_LEVEL: n_state = S_SCALE;
            S_SCALE: n_state = S_PCT;
            S_PCT:   n_state = S_DIV;
            S_DIV:   n_state = (r_phase == PH_C) ? S_DONE : S_ADDR;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        w_rom_addr    = r_idx;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_ADDR:  w_rom_addr    = w_phase_ang[31 -: IDX_W];
            S_RD1:   w_rom_addr    = r_idx + IDX_W'(1);
            S_DONE:  w_load_out    = w_out_free;
            default: begin
                // hold defaults
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Phase counter: start at A, advance after each divide step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_A;
        end else if (r_state == S_ELEC) begin
            r_phase <= PH_A;
        end else if (r_state == S_DIV) begin
            case (r_phase)
                PH_A:    r_phase <= PH_B;
                PH_B:    r_phase <= PH_C;
                default: r_phase <= PH_A;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sine ROM
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_TABLE[w_rom_addr];
    end

    // ------------------------------------------------------------------
    // Angle state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (r_state == S_ANGLE) begin
            if (r_neg) begin
                r_angle <= r_angle - w_p_rnd[6 +: 32];
            end else begin
                r_angle <= r_angle + r_p[6 +: 32];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared datapath, at most one multiply per step
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    r_speed <= s_axis_tdata[15:0];
                    r_dt    <= s_axis_tdata[31:16];
                end
            end
            S_MUL1: begin
                r_neg  <= r_speed[15];
                r_prod <= 32'(w_mag) * 32'(r_dt);
            end
            S_MUL2:  r_p    <= P_W'(r_prod) * P_W'(SPEED_GAIN);
            S_ELEC:  r_elec <= r_angle * {26'd0, r_ppc};
            S_ADDR: begin
                r_idx  <= w_phase_ang[31 -: IDX_W];
                r_frac <= w_phase_ang[FRAC_W-1:0];
            end
            S_RD1:   r_u0  <= r_rom_q ^ 16'h8000;
            S_RD2:   r_mix <= MIX_W'(w_diff) * MIX_W'($signed({1'b0, r_frac}));
            S_LEVEL: r_v   <= w_lvl[15:0];
            S_SCALE: r_scl <= 32'(r_v) * 32'(r_period);
            S_PCT:   r_x   <= w_x_full[38:16];
            S_DIV: begin
                case (r_phase)
                    PH_A:    r_duty_a <= w_q;
                    PH_B:    r_duty_b <= w_q;
                    default: r_duty_c <= w_q;
                endcase
            end
            default: begin
                // hold datapath
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {r_duty_c, r_duty_b, r_duty_a};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // An accepted request takes the sequencer out of idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer stayed idle after accepting a request");

    // The angle moves only in its update step
    a_angle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ANGLE) |=> $stable(r_angle))
        else $error("mechanical angle changed outside its update step");

    // Loading the output register presents the three finished duties
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (m_axis_tvalid
                        && m_axis_tdata == $past({r_duty_c, r_duty_b, r_duty_a})))
        else $error("output register not loaded with the finished duties");
`endif

endmodule
